>>> sv/nearest_segment_hit_clip_top_macros.svh
`ifndef NEAREST_SEGMENT_HIT_CLIP_TOP_MACROS_SVH
`define NEAREST_SEGMENT_HIT_CLIP_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define NSHC_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("nshc assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define NSHC_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("nshc assertion failed");

`endif

>>> sv/nshc_pkg.sv
`timescale 1ns / 1ps

package nshc_pkg;

    // Internal arithmetic wraps modulo 2^64.
    localparam int IW = 64;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_END_X   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_Y   = 3'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_EVAL,
        ST_OUT
    } state_t;

    // Product sequence: even steps fill the temporary, odd steps subtract from it.
    typedef enum logic [3:0] {
        STEP_AXBY,
        STEP_BXAY,
        STEP_SXEY,
        STEP_EXSY,
        STEP_DXA_DYS,
        STEP_DYA_DXS,
        STEP_CA_DXS,
        STEP_CS_DXA,
        STEP_CA_DYS,
        STEP_CS_DYA
    } step_t;

endpackage

>>> sv/nshc_mul.sv
`timescale 1ns / 1ps

module nshc_mul #(
    parameter int BW = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [nshc_pkg::IW-1:0] a,
    input  logic [BW-1:0]        b,
    output logic                 done,
    output logic [nshc_pkg::IW-1:0] prod
);
    import nshc_pkg::*;

    localparam int CNTW = $clog2(BW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0]   acc_reg, acc_next;
    logic [IW-1:0]   mcand_reg, mcand_next;
    logic [BW-1:0]   mplier_reg, mplier_next;
    logic            last;

    assign last = (cnt_reg == CNTW'(BW - 1));

    // Signed shift-add: the top multiplier bit carries negative weight.
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = a;
            mplier_next = b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = last ? (acc_reg - mcand_reg) : (acc_reg + mcand_reg);
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> sv/nshc_div.sv
`timescale 1ns / 1ps

module nshc_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [nshc_pkg::IW-1:0] num,
    input  logic [nshc_pkg::IW-1:0] den,
    output logic                    done,
    output logic [nshc_pkg::IW-1:0] quot
);
    import nshc_pkg::*;

    localparam int CNTW = $clog2(IW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            neg_reg, neg_next;
    logic [IW-1:0]   rem_reg, rem_next;
    logic [IW-1:0]   quo_reg, quo_next;
    logic [IW-1:0]   dvs_reg, dvs_next;
    logic [IW-1:0]   shifted;
    logic            ge;

    // The remainder stays below the divisor magnitude, at most 2^63, so its
    // top bit is always clear and the shift loses nothing.
    assign shifted = {rem_reg[IW-2:0], quo_reg[IW-1]};
    assign ge      = (shifted >= dvs_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = num[IW-1] ^ den[IW-1];
            rem_next  = '0;
            quo_next  = num[IW-1] ? (~num + 1'b1) : num;
            dvs_next  = den[IW-1] ? (~den + 1'b1) : den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (shifted - dvs_reg) : shifted;
            quo_next = {quo_reg[IW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(IW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

>>> sv/nearest_segment_hit_clip_top.sv
`timescale 1ns / 1ps

// Clips the query segment from the configured start to the current end against
// each obstacle segment in turn and keeps the nearest crossing. One request
// gives exactly one result. Ten products go one multiplier bit per cycle
// through a single shift-add multiplier, and the two coordinates come one
// quotient bit per cycle from a single restoring divider. Requests with
// parallel lines skip the divider. The input side is stalled while a request
// is worked on; a finished result waits in the output register while the
// next request is taken.
module nearest_segment_hit_clip_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nshc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]           cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             restart,
    input  logic signed [COORD_WIDTH-1:0]    seg_ax,
    input  logic signed [COORD_WIDTH-1:0]    seg_ay,
    input  logic signed [COORD_WIDTH-1:0]    seg_bx,
    input  logic signed [COORD_WIDTH-1:0]    seg_by,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             hit,
    output logic signed [COORD_WIDTH-1:0]    end_x,
    output logic signed [COORD_WIDTH-1:0]    end_y,
    output logic [COORD_WIDTH:0]             best_dist
);
    import nshc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int BW = COORD_WIDTH + 1;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    logic [W-1:0] start_x_reg, start_y_reg, init_x_reg, init_y_reg;
    logic [W-1:0] end_x_reg, end_x_next, end_y_reg, end_y_next;
    logic [W:0]   best_reg, best_next;
    logic         hit_reg, hit_next;

    logic [W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [IW-1:0] tmp_reg, ca_reg, cs_reg, den_reg, xnum_reg, ynum_reg;
    logic [IW-1:0] qx_reg, qy_reg;

    logic         out_valid_reg, out_valid_next;
    logic         out_hit_reg;
    logic [W-1:0] out_x_reg, out_y_reg;
    logic [W:0]   out_dist_reg;

    logic          accept, out_free;
    logic          mul_start, mul_done, div_start, div_done;
    logic [IW-1:0] mul_a, mul_prod, div_quot, diff;
    logic [BW-1:0] mul_b;
    logic [BW-1:0] dxa, dya, dxs, dys;
    logic [IW-1:0] ax64, ay64, bx64, by64, sx64, sy64, ex64, ey64;
    logic          in_span, nearer;
    logic [IW-1:0] hit_dist;

    function automatic logic [IW-1:0] sx_c(input logic [W-1:0] v);
        return {{(IW - W){v[W-1]}}, v};
    endfunction

    function automatic logic [IW-1:0] sx_d(input logic [BW-1:0] v);
        return {{(IW - BW){v[BW-1]}}, v};
    endfunction

    function automatic logic [BW-1:0] wb(input logic [W-1:0] v);
        return {v[W-1], v};
    endfunction

    function automatic logic outside(input logic signed [IW-1:0] v,
                                     input logic signed [IW-1:0] p,
                                     input logic signed [IW-1:0] q);
        return ((v > p) && (v > q)) || ((v < p) && (v < q));
    endfunction

    function automatic logic [IW-1:0] mag(input logic [IW-1:0] v);
        return v[IW-1] ? (~v + 1'b1) : v;
    endfunction

    assign ax64 = sx_c(ax_reg);
    assign ay64 = sx_c(ay_reg);
    assign bx64 = sx_c(bx_reg);
    assign by64 = sx_c(by_reg);
    assign sx64 = sx_c(start_x_reg);
    assign sy64 = sx_c(start_y_reg);
    assign ex64 = sx_c(end_x_reg);
    assign ey64 = sx_c(end_y_reg);

    assign dxa = wb(ax_reg) - wb(bx_reg);
    assign dya = wb(ay_reg) - wb(by_reg);
    assign dxs = wb(start_x_reg) - wb(end_x_reg);
    assign dys = wb(start_y_reg) - wb(end_y_reg);

    assign diff = tmp_reg - mul_prod;

    // Operand selection for the shared multiplier; B is always the narrow one.
    always_comb
    begin
        case (step_reg)
            STEP_AXBY:    begin mul_a = ax64;       mul_b = wb(by_reg);      end
            STEP_BXAY:    begin mul_a = bx64;       mul_b = wb(ay_reg);      end
            STEP_SXEY:    begin mul_a = sx64;       mul_b = wb(end_y_reg);   end
            STEP_EXSY:    begin mul_a = ex64;       mul_b = wb(start_y_reg); end
            STEP_DXA_DYS: begin mul_a = sx_d(dxa);  mul_b = dys;             end
            STEP_DYA_DXS: begin mul_a = sx_d(dya);  mul_b = dxs;             end
            STEP_CA_DXS:  begin mul_a = ca_reg;     mul_b = dxs;             end
            STEP_CS_DXA:  begin mul_a = cs_reg;     mul_b = dxa;             end
            STEP_CA_DYS:  begin mul_a = ca_reg;     mul_b = dys;             end
            STEP_CS_DYA:  begin mul_a = cs_reg;     mul_b = dya;             end
            default:      begin mul_a = '0;         mul_b = '0;              end
        endcase
    end

    nshc_mul #(.BW(BW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    nshc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ((state_reg == ST_DIVX_GO) ? xnum_reg : ynum_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // The crossing must lie in the closed spans of both segments.
    assign in_span  = !(outside(qx_reg, ax64, bx64) || outside(qx_reg, sx64, ex64) ||
                        outside(qy_reg, ay64, by64) || outside(qy_reg, sy64, ey64));
    assign hit_dist = mag(sx64 - qx_reg) + mag(sy64 - qy_reg);
    assign nearer   = (hit_dist < {{(IW - W - 1){1'b0}}, best_reg}) || (best_reg == '0);

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_MUL_GO;
            ST_MUL_GO:    state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    if (step_reg == STEP_DYA_DXS && diff == '0)
                        state_next = ST_OUT;
                    else if (step_reg == STEP_CS_DYA)
                        state_next = ST_DIVX_GO;
                    else
                        state_next = ST_MUL_GO;
                end
            end
            ST_DIVX_GO:   state_next = ST_DIVX_WAIT;
            ST_DIVX_WAIT: if (div_done) state_next = ST_DIVY_GO;
            ST_DIVY_GO:   state_next = ST_DIVY_WAIT;
            ST_DIVY_WAIT: if (div_done) state_next = ST_EVAL;
            ST_EVAL:      state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        mul_start = (state_reg == ST_MUL_GO);
        div_start = (state_reg == ST_DIVX_GO) || (state_reg == ST_DIVY_GO);
    end

    always_comb
    begin
        step_next      = step_reg;
        end_x_next     = end_x_reg;
        end_y_next     = end_y_reg;
        best_next      = best_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (accept)
        begin
            step_next = STEP_AXBY;
            hit_next  = 1'b0;
            if (restart)
            begin
                end_x_next = init_x_reg;
                end_y_next = init_y_reg;
                best_next  = '0;
            end
        end
        if (state_reg == ST_MUL_WAIT && mul_done && step_reg != STEP_CS_DYA)
            step_next = step_t'(step_reg + 4'd1);
        if (state_reg == ST_EVAL && in_span && nearer)
        begin
            end_x_next = qx_reg[W-1:0];
            end_y_next = qy_reg[W-1:0];
            best_next  = hit_dist[W:0];
            hit_next   = 1'b1;
        end
        if (state_reg == ST_OUT && out_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_AXBY;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            init_x_reg    <= '0;
            init_y_reg    <= '0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
            best_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            best_reg      <= best_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START_X: start_x_reg <= cfg_data;
                    REG_START_Y: start_y_reg <= cfg_data;
                    REG_END_X:   init_x_reg  <= cfg_data;
                    REG_END_Y:   init_y_reg  <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= seg_ax;
            ay_reg <= seg_ay;
            bx_reg <= seg_bx;
            by_reg <= seg_by;
        end
        if (state_reg == ST_MUL_WAIT && mul_done)
        begin
            case (step_reg)
                STEP_BXAY:    ca_reg   <= diff;
                STEP_EXSY:    cs_reg   <= diff;
                STEP_DYA_DXS: den_reg  <= diff;
                STEP_CS_DXA:  xnum_reg <= diff;
                STEP_CS_DYA:  ynum_reg <= diff;
                default:      tmp_reg  <= mul_prod;
            endcase
        end
        if (state_reg == ST_DIVX_WAIT && div_done)
            qx_reg <= div_quot;
        if (state_reg == ST_DIVY_WAIT && div_done)
            qy_reg <= div_quot;
        if (state_reg == ST_OUT && out_free)
        begin
            out_hit_reg  <= hit_reg;
            out_x_reg    <= end_x_reg;
            out_y_reg    <= end_y_reg;
            out_dist_reg <= best_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign end_x     = out_x_reg;
    assign end_y     = out_y_reg;
    assign best_dist = out_dist_reg;

endmodule

>>> sv/nshc_checker.sv
`timescale 1ns / 1ps

`include "nearest_segment_hit_clip_top_macros.svh"

module nshc_checker #(
    parameter int COORD_WIDTH = 16
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [nshc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [COORD_WIDTH-1:0]           cfg_data,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             restart,
    input logic [COORD_WIDTH-1:0]           seg_ax,
    input logic [COORD_WIDTH-1:0]           seg_ay,
    input logic [COORD_WIDTH-1:0]           seg_bx,
    input logic [COORD_WIDTH-1:0]           seg_by,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             hit,
    input logic [COORD_WIDTH-1:0]           end_x,
    input logic [COORD_WIDTH-1:0]           end_y,
    input logic [COORD_WIDTH:0]             best_dist
);

    // A stalled result must hold its payload.
    `NSHC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(hit) && $stable(end_x) && $stable(end_y) && $stable(best_dist))

    // Once a request is taken the block is busy with it.
    `NSHC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall && !$rose(out_valid))

    // A result only disappears after it has been taken.
    `NSHC_ASSERT_NOW(a_out_taken, $fell(out_valid), $past(!out_stall))

    // Register writes are never refused.
    `NSHC_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind nearest_segment_hit_clip_top nshc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_nshc_checker (.*);
